>>> design/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants, register indexes and handshake types of the 2-D median
// filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int MAX_WINDOW_DEF = 5;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int HEIGHT_LIMIT   = 1024;
  localparam int ROW_BITS       = 10;
  localparam int OUT_FIFO_DEPTH = 8;

  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 11;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam logic [2:0]  WINDOW_SIZE_RST  = 3'd3;
  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd1024;

  // Control travelling with a window through the median pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } res_ctl_t;

endpackage

>>> design/mf2d_ram.sv
// ----------------------------------------------------------------------------
// mf2d_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mf2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mf2d_fifo.sv
// ----------------------------------------------------------------------------
// mf2d_fifo
// Small register FIFO that buffers finished results in front of the output
// channel and reports its fill level for credit-based input flow control.
// ----------------------------------------------------------------------------
module mf2d_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CW'(DEPTH)) || do_pop)
    else $error("result buffer written while full");
`endif

endmodule

>>> design/mf2d_median.sv
// ----------------------------------------------------------------------------
// mf2d_median
// Pipelined rank-select median of the active part of the window: pairwise
// compare, rank by popcount, then one-hot select of the middle rank.
// ----------------------------------------------------------------------------
module mf2d_median #(
  parameter int MAX_WINDOW = mf2d_pkg::MAX_WINDOW_DEF,
  parameter int PIXEL_BITS = mf2d_pkg::PIXEL_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mf2d_pkg::res_ctl_t                      in_ctl,
  input  logic [MAX_WINDOW*MAX_WINDOW*PIXEL_BITS-1:0] win_flat,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]         w_eff,
  output mf2d_pkg::res_ctl_t                      out_ctl,
  output logic [PIXEL_BITS-1:0]                   median
);

  localparam int M  = MAX_WINDOW;
  localparam int N  = M * M;
  localparam int RW = $clog2(N+1);
  localparam int WW = $clog2(M+1);

  logic [PIXEL_BITS-1:0] vals [N];
  logic [N-1:0]          act;
  logic [RW-1:0]         half;
  logic [N-1:0]          bef [N];

  mf2d_pkg::res_ctl_t    ctl_a_r, ctl_b_r, ctl_c_r;
  logic [N-1:0]          bef_a_r [N];
  logic [PIXEL_BITS-1:0] vals_a_r [N];
  logic [PIXEL_BITS-1:0] vals_b_r [N];
  logic [N-1:0]          act_a_r, act_b_r;
  logic [RW-1:0]         half_a_r, half_b_r;
  logic [RW-1:0]         rank_b_r [N];
  logic [N-1:0]          sel;
  logic [PIXEL_BITS-1:0] med_nxt, med_r;

  // Element k*M+col: k lines back, col M-1 is the newest column
  for (genvar k = 0; k < M; k++) begin : g_row
    for (genvar c = 0; c < M; c++) begin : g_col
      assign vals[k*M+c] = win_flat[(k*M+c)*PIXEL_BITS +: PIXEL_BITS];
      assign act[k*M+c]  = (WW'(k) < w_eff) && (WW'(M-1-c) < w_eff);
    end
  end

  assign half = RW'((32'(w_eff) * 32'(w_eff)) >> 1);

  // Ties broken by position so that ranks form a permutation
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        bef[i][j] = act[j] && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < N; i++) begin
      sel[i] = act_b_r[i] && (rank_b_r[i] == half_b_r);
      med_nxt = med_nxt | (sel[i] ? vals_b_r[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      bef_a_r[i]  <= bef[i];
      vals_a_r[i] <= vals[i];
      vals_b_r[i] <= vals_a_r[i];
      rank_b_r[i] <= RW'($countones(bef_a_r[i]));
    end
    act_a_r  <= act;
    act_b_r  <= act_a_r;
    half_a_r <= half;
    half_b_r <= half_a_r;
    med_r    <= med_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      ctl_a_r <= in_ctl;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  assign out_ctl = ctl_c_r;
  assign median  = med_r;

`ifndef ASSERT_OFF
  a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_b_r.valid |-> $onehot(sel))
    else $error("median select is not one-hot");
`endif

endmodule

>>> design/median_filter_2d.sv
// ----------------------------------------------------------------------------
// median_filter_2d
// Streaming square-window median filter for grey pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ channel (valid/ready), one beat per pixel, frames
// back to back in raster order. For every pixel that completes a full
// window the median of that window leaves on the out_ channel, with
// out_last_of_frame set on the final window of the frame; other pixels give
// no beat. Window side, width and height are written on the cfg_ port while
// the block is idle; a write restarts the frame.
// One pixel is taken per cycle while in_ready is high. The previous lines live
// in one RAM word per column, read and written back once per pixel; the median
// is a three-stage compare/rank/select pipeline. A result is offered on out_valid
// after its pixel has passed the input register, the window, those stages and the buffer.
// Results queue in an 8-entry buffer; in_ready drops only when that buffer
// plus the results still in the pipeline would fill it, so a stalled
// receiver holds the input back without losing anything.
// Reset empties the pipeline and buffer, returns to the start of a frame and
// loads window 3, 1024 by 1024. The line RAM needs no clearing.
// ----------------------------------------------------------------------------
module median_filter_2d #(
  parameter int MAX_WINDOW = mf2d_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mf2d_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [PIXEL_BITS-1:0]              in_pixel_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [PIXEL_BITS-1:0]              out_median_value,
  output logic                               out_last_of_frame,
  input  logic                               cfg_wr_en,
  input  logic [mf2d_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mf2d_pkg::CFG_DATA_BITS-1:0] cfg_wr_data
);

  localparam int M     = MAX_WINDOW;
  localparam int L     = (M > 1) ? M - 1 : 1;
  localparam int N     = M * M;
  localparam int WW    = $clog2(M+1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CWW   = $clog2(MAX_WIDTH+1);
  localparam int RB    = mf2d_pkg::ROW_BITS;
  localparam int HW    = $clog2(mf2d_pkg::HEIGHT_LIMIT+1);
  localparam int FD    = mf2d_pkg::OUT_FIFO_DEPTH;
  localparam int FCW   = $clog2(FD+1);

  logic [2:0]   win_size_r;
  logic [10:0]  img_w_r, img_h_r;
  logic [WW-1:0]  w_eff;
  logic [CWW-1:0] wd_eff;
  logic [HW-1:0]  ht_eff;
  logic [CW-1:0]  wd_last;
  logic [RB-1:0]  ht_last;

  logic [CW-1:0] col_r;
  logic [RB-1:0] row_r;
  logic          accept, produce, is_last, col_end, row_end, cfg_hit;

  logic                  s1_v_r, s1_prod_r, s1_last_r;
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic [CW-1:0]         s1_col_r;

  logic [L*PIXEL_BITS-1:0] ram_rdata, lines_rd, line_wr, fwd_data_r;
  logic                    fwd_r;

  logic [PIXEL_BITS-1:0] win_r [M][M];
  logic [N*PIXEL_BITS-1:0] win_flat;
  mf2d_pkg::res_ctl_t    win_ctl_r, med_ctl;
  logic [PIXEL_BITS-1:0] med_val;

  logic [FCW-1:0] infl_r, fifo_cnt;
  logic [PIXEL_BITS:0] fifo_head;

  // Effective sizes: zero counts as one, oversize saturates
  always_comb begin
    if (win_size_r == '0)            w_eff = WW'(1);
    else if (32'(win_size_r) > M)    w_eff = WW'(M);
    else                             w_eff = WW'(win_size_r);
    if (img_w_r == '0)               wd_eff = CWW'(1);
    else if (32'(img_w_r) > MAX_WIDTH) wd_eff = CWW'(MAX_WIDTH);
    else                             wd_eff = CWW'(img_w_r);
    if (img_h_r == '0)               ht_eff = HW'(1);
    else if (32'(img_h_r) > mf2d_pkg::HEIGHT_LIMIT) ht_eff = HW'(mf2d_pkg::HEIGHT_LIMIT);
    else                             ht_eff = HW'(img_h_r);
  end

  assign wd_last = CW'(wd_eff - 1'b1);
  assign ht_last = RB'(ht_eff - 1'b1);

  assign accept  = in_valid && in_ready;
  assign col_end = (col_r == wd_last);
  assign row_end = (row_r == ht_last);
  assign produce = (32'(row_r) + 1 >= 32'(w_eff)) && (32'(col_r) + 1 >= 32'(w_eff));
  assign is_last = col_end && row_end;
  assign cfg_hit = cfg_wr_en && ((cfg_index == mf2d_pkg::CFG_WINDOW_SIZE) ||
                                 (cfg_index == mf2d_pkg::CFG_IMAGE_WIDTH) ||
                                 (cfg_index == mf2d_pkg::CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= mf2d_pkg::WINDOW_SIZE_RST;
      img_w_r    <= mf2d_pkg::IMAGE_WIDTH_RST;
      img_h_r    <= mf2d_pkg::IMAGE_HEIGHT_RST;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        mf2d_pkg::CFG_WINDOW_SIZE:  win_size_r <= cfg_wr_data[2:0];
        mf2d_pkg::CFG_IMAGE_WIDTH:  img_w_r    <= cfg_wr_data;
        mf2d_pkg::CFG_IMAGE_HEIGHT: img_h_r    <= cfg_wr_data;
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Line store: one word per column holding the last L lines, newest lowest
  mf2d_ram #(
    .WIDTH (L*PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (line_wr),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign lines_rd = fwd_r ? fwd_data_r : ram_rdata;

  always_comb begin
    line_wr = '0;
    line_wr[PIXEL_BITS-1:0] = s1_px_r;
    for (int a = 1; a < L; a++) begin
      line_wr[a*PIXEL_BITS +: PIXEL_BITS] = lines_rd[(a-1)*PIXEL_BITS +: PIXEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r    <= in_pixel_value;
    s1_col_r   <= col_r;
    s1_last_r  <= is_last;
    // One-column frames read the word being written back this cycle
    fwd_data_r <= line_wr;
    for (int k = 0; k < M; k++) begin
      if (s1_v_r) begin
        for (int c = 0; c < M-1; c++) begin
          win_r[k][c] <= win_r[k][c+1];
        end
        win_r[k][M-1] <= (k == 0) ? s1_px_r :
                         lines_rd[((k > 0 ? k : 1) - 1)*PIXEL_BITS +: PIXEL_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_prod_r <= 1'b0;
      fwd_r     <= 1'b0;
      win_ctl_r <= '0;
      infl_r    <= '0;
    end else begin
      s1_v_r          <= accept;
      s1_prod_r       <= accept && produce;
      fwd_r           <= accept && s1_v_r && (col_r == s1_col_r);
      win_ctl_r.valid <= s1_v_r && s1_prod_r;
      win_ctl_r.last  <= s1_last_r;
      if ((accept && produce) && !med_ctl.valid) begin
        infl_r <= infl_r + 1'b1;
      end else if (!(accept && produce) && med_ctl.valid) begin
        infl_r <= infl_r - 1'b1;
      end
    end
  end

  for (genvar k = 0; k < M; k++) begin : g_flat_row
    for (genvar c = 0; c < M; c++) begin : g_flat_col
      assign win_flat[(k*M+c)*PIXEL_BITS +: PIXEL_BITS] = win_r[k][c];
    end
  end

  mf2d_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (win_ctl_r),
    .win_flat (win_flat),
    .w_eff    (w_eff),
    .out_ctl  (med_ctl),
    .median   (med_val)
  );

  mf2d_fifo #(
    .WIDTH (PIXEL_BITS+1),
    .DEPTH (FD)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (med_ctl.valid),
    .push_data ({med_ctl.last, med_val}),
    .pop       (out_ready),
    .head_data (fifo_head),
    .not_empty (out_valid),
    .count     (fifo_cnt)
  );

  assign out_median_value  = fifo_head[PIXEL_BITS-1:0];
  assign out_last_of_frame = fifo_head[PIXEL_BITS];
  assign in_ready = ((FCW+1)'(fifo_cnt) + (FCW+1)'(infl_r)) < (FCW+1)'(FD);

`ifndef ASSERT_OFF
  a_fwd_one_col: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (wd_last == '0))
    else $error("line store forward outside a one-column frame");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ((FCW+1)'(fifo_cnt) + (FCW+1)'(infl_r)) <= (FCW+1)'(FD))
    else $error("results in flight exceed buffer space");
`endif

endmodule

>>> bench/tb_median_filter_2d.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_filter_2d
// Self-checking bench for the streaming 2-D median filter.
// ----------------------------------------------------------------------------
// Frames of grey pixels are streamed under a series of window, width and
// height settings, the extremes included. A scoreboard keeps its own line
// store and window, predicts each median with its end-of-frame flag and
// checks every output beat in order. The sender bursts and idles at random
// and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_median_filter_2d;

  localparam int IW = mf2d_pkg::CFG_IDX_BITS;
  localparam int DW = mf2d_pkg::CFG_DATA_BITS;
  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
  localparam int WIN   = 5;
  localparam int LINES = WIN - 1;
  localparam int WMAX  = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int TARGET_PIXELS  = 1550;

  class median_scoreboard;
    logic [7:0]  line_mem [LINES][WMAX];
    logic [7:0]  win_regs [WIN][WIN];
    int unsigned win_side, frame_w, frame_h, col, row;
    logic [7:0]  median_q [$];
    logic        last_q [$];
    int          errors;

    function new();
      win_side = mf2d_pkg::WINDOW_SIZE_RST;
      frame_w  = mf2d_pkg::IMAGE_WIDTH_RST;
      frame_h  = mf2d_pkg::IMAGE_HEIGHT_RST;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        mf2d_pkg::CFG_WINDOW_SIZE:  win_side = val[2:0];
        mf2d_pkg::CFG_IMAGE_WIDTH:  frame_w  = val;
        mf2d_pkg::CFG_IMAGE_HEIGHT: frame_h  = val;
        default: return;
      endcase
      col = 0;
      row = 0;
    endfunction

    function int pending();
      return median_q.size();
    endfunction

    // Advance the window by one pixel and queue a median if it is complete
    function void note_pixel(logic [7:0] px);
      int unsigned w, wd, ht, c, r, cur, k, n;
      logic [7:0] vals [WIN*WIN];
      logic [7:0] t;
      w  = clamp(win_side, WIN);
      wd = clamp(frame_w, WMAX);
      ht = clamp(frame_h, 1024);
      c  = (col >= wd) ? wd - 1 : col;
      r  = (row >= ht) ? ht - 1 : row;
      cur = r % LINES;
      for (int i = 0; i < w; i++) begin
        k = w - 1 - i;
        for (int j = 0; j + 1 < w; j++) win_regs[i][j] = win_regs[i][j+1];
        win_regs[i][w-1] = (k == 0) ? px : line_mem[(cur + LINES - k) % LINES][c];
      end
      line_mem[cur][c] = px;
      if (r + 1 >= w && c + 1 >= w) begin
        n = 0;
        for (int i = 0; i < w; i++)
          for (int j = 0; j < w; j++) begin
            vals[n] = win_regs[i][j];
            n++;
          end
        for (int i = 1; i < n; i++) begin
          t = vals[i];
          k = i;
          while (k > 0 && vals[k-1] > t) begin
            vals[k] = vals[k-1];
            k--;
          end
          vals[k] = t;
        end
        median_q.insert(median_q.size(), vals[n/2]);
        last_q.insert(last_q.size(), r == ht - 1 && c == wd - 1);
      end
      if (c + 1 >= wd) begin
        col = 0;
        row = (r + 1 >= ht) ? 0 : r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_beat(logic [7:0] med, logic last);
      logic [7:0] em;
      logic el;
      if (median_q.size() == 0) begin
        report($sformatf("unexpected beat median=%0d last=%0b", med, last));
        return;
      end
      em = median_q.pop_front();
      el = last_q.pop_front();
      if (med !== em) report($sformatf("median got %0d want %0d", med, em));
      if (last !== el) report($sformatf("last_of_frame got %0b want %0b", last, el));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_median_value;
  logic out_last_of_frame;
  logic cfg_wr_en = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_wr_data = '0;

  median_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned sent = 0;
  logic [7:0] base_px;

  always #1 clk = ~clk;

  median_filter_2d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_median_value(out_median_value), .out_last_of_frame(out_last_of_frame),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  // Monitor both channels and guard against a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_pixel_value);
      if (out_valid && out_ready) sb.check_beat(out_median_value, out_last_of_frame);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver stalls: free-flowing, random, short periodic stalls, then long blocked stretches
  always @(posedge clk) begin
    case (cycle_cnt[10:9])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(1, 0));
      2'd2: out_ready <= (cycle_cnt[4:0] < 5'd24);
      default: out_ready <= (cycle_cnt[5:0] >= 6'd40);
    endcase
  end

  task write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task configure(int unsigned w, int unsigned wd, int unsigned ht);
    write_reg(mf2d_pkg::CFG_WINDOW_SIZE, DW'(w));
    write_reg(mf2d_pkg::CFG_IMAGE_WIDTH, DW'(wd));
    write_reg(mf2d_pkg::CFG_IMAGE_HEIGHT, DW'(ht));
  endtask

  // Hold the beat until ready was seen high ahead of an edge
  task send_pixel(logic [7:0] px);
    logic hs;
    in_valid <= 1'b1;
    in_pixel_value <= px;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
    sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [7:0] pick_pixel();
    case ($urandom_range(3, 0))
      0: return 8'($urandom_range(255, 0));
      1: return $urandom_range(1, 0) ? 8'd255 : 8'd0;
      default: return 8'(base_px + $urandom_range(3, 0));
    endcase
  endfunction

  // Stream n pixels in bursts; pause halfway until all medians are out
  task stream(int unsigned n);
    int unsigned burst, gap;
    burst = 0;
    base_px = 8'($urandom_range(255, 0));
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(40, 1);
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_pixel(pick_pixel());
      burst--;
    end
    drain();
  endtask

  task run_phase(int unsigned w, int unsigned wd, int unsigned ht, int unsigned frames);
    int unsigned fw, fh;
    configure(w, wd, ht);
    fw = (wd == 0) ? 1 : (wd > WMAX ? WMAX : wd);
    fh = (ht == 0) ? 1 : (ht > 1024 ? 1024 : ht);
    stream(frames * fw * fh);
  endtask

  initial begin
    int unsigned w, wd, ht;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: early pixels of a 1024 line frame give nothing
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    drain();

    // Directed 5x5 frame with extremes under a 3x3 window
    configure(3, 5, 5);
    for (int i = 0; i < 25; i++)
      send_pixel((i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd0 : 8'(i * 37)));
    drain();

    // Stray register index must change nothing
    write_reg(CFG_UNUSED, 11'h7ff);
    stream(25);

    run_phase(1, 1, 1, 3);
    run_phase(5, 5, 5, 2);
    run_phase(0, 0, 0, 2);
    run_phase(7, 6, 6, 1);
    run_phase(4, 7, 5, 1);
    run_phase(2, 4, 3, 2);
    run_phase(5, 3, 8, 1);
    run_phase(5, 8, 3, 1);
    run_phase(1, 2047, 0, 1);
    run_phase(5, 1024, 5, 0);
    stream(60);

    while (sent < TARGET_PIXELS) begin
      w  = $urandom_range(7, 0);
      wd = $urandom_range(16, 1);
      ht = $urandom_range(12, 1);
      run_phase(w, wd, ht, 1);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
